### rtl/core/kgc_pkg.sv
`default_nettype none

package kgc_pkg;

    localparam int HISTORY_DEPTH_DEF = 20;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 8;
    localparam int GEST_W     = 4;
    localparam int MIN_KEYS_W = 5;
    localparam int PRESS_W    = 5;

    localparam logic [1:0] REG_TAP_LIMIT  = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_DTAP_WIN   = 2'd2;
    localparam logic [1:0] REG_MIN_KEYS   = 2'd3;

    localparam logic [15:0] TAP_LIMIT_RST  = 16'd200;
    localparam logic [15:0] LONG_PRESS_RST = 16'd500;
    localparam logic [15:0] DTAP_WIN_RST   = 16'd500;
    localparam logic [4:0]  MIN_KEYS_RST   = 5'd3;

    localparam logic [PRESS_W-1:0] PRESS_MAX = 5'd31;

    localparam logic [GEST_W-1:0] GEST_TAP        = 4'd0;
    localparam logic [GEST_W-1:0] GEST_DOUBLE_TAP = 4'd1;
    localparam logic [GEST_W-1:0] GEST_LONG_PRESS = 4'd2;
    localparam logic [GEST_W-1:0] GEST_UP         = 4'd3;
    localparam logic [GEST_W-1:0] GEST_DOWN       = 4'd4;
    localparam logic [GEST_W-1:0] GEST_LEFT       = 4'd5;
    localparam logic [GEST_W-1:0] GEST_RIGHT      = 4'd6;
    localparam logic [GEST_W-1:0] GEST_PINCH_IN   = 4'd7;
    localparam logic [GEST_W-1:0] GEST_PINCH_OUT  = 4'd8;

    typedef struct packed {
        logic [15:0] tap_limit_ms;
        logic [15:0] long_press_ms;
        logic [15:0] double_tap_window_ms;
        logic [4:0]  min_swipe_keys;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic measure;
        logic apply;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic has_result;
        logic out_free;
    } stat_t;

    // key index 0..15 of the lowest touched key
    function automatic logic [3:0] lowest_index(input logic [15:0] bits);
        logic [3:0] idx;
        idx = 4'd0;
        for (int i = 15; i >= 0; i--) begin
            if (bits[i]) begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic is_corner(input logic [3:0] idx);
        return idx inside {4'd0, 4'd3, 4'd12, 4'd15};
    endfunction

    function automatic logic is_centre(input logic [3:0] idx);
        return idx inside {4'd5, 4'd6, 4'd9, 4'd10};
    endfunction

endpackage

`default_nettype wire

### rtl/core/kgc_regs.sv
`default_nettype none

module kgc_regs
    import kgc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tap_limit_ms         <= TAP_LIMIT_RST;
            cfg_reg.long_press_ms        <= LONG_PRESS_RST;
            cfg_reg.double_tap_window_ms <= DTAP_WIN_RST;
            cfg_reg.min_swipe_keys       <= MIN_KEYS_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_TAP_LIMIT:  cfg_reg.tap_limit_ms         <= pwdata[15:0];
                REG_LONG_PRESS: cfg_reg.long_press_ms        <= pwdata[15:0];
                REG_DTAP_WIN:   cfg_reg.double_tap_window_ms <= pwdata[15:0];
                REG_MIN_KEYS:   cfg_reg.min_swipe_keys       <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TAP_LIMIT:  prdata = {16'd0, cfg_reg.tap_limit_ms};
            REG_LONG_PRESS: prdata = {16'd0, cfg_reg.long_press_ms};
            REG_DTAP_WIN:   prdata = {16'd0, cfg_reg.double_tap_window_ms};
            REG_MIN_KEYS:   prdata = {27'd0, cfg_reg.min_swipe_keys};
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/kgc_ctrl.sv
`default_nettype none

module kgc_ctrl
    import kgc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_MEASURE = 4'b0010,
        S_APPLY   = 4'b0100,
        S_CHECK   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done;

    assign s_tready = (state_reg == S_IDLE);
    assign done     = !stat.has_result || stat.out_free;

    assign cmd.capture = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.measure = (state_reg == S_MEASURE);
    assign cmd.apply   = (state_reg == S_APPLY);
    assign cmd.commit  = (state_reg == S_CHECK) && done;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (s_tvalid) state_next = S_MEASURE;
            S_MEASURE: state_next = S_APPLY;
            S_APPLY:   state_next = S_CHECK;
            S_CHECK:   if (done) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/kgc_dp.sv
`default_nettype none

module kgc_dp
    import kgc_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cmd_t                cmd,
    output stat_t                    stat,
    input  wire cfg_t                cfg,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata
);

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int CMP_W  = (FILL_W > MIN_KEYS_W) ? FILL_W : MIN_KEYS_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);

    logic [15:0]        bits_reg;
    logic [31:0]        now_reg;
    logic [15:0]        prev_reg;
    logic [31:0]        start_reg;
    logic [31:0]        last_tap_reg;
    logic               lp_done_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [PRESS_W-1:0] press_reg;
    logic [3:0]         first_reg;
    logic [3:0]         last_reg;

    logic               changed_reg;
    logic               rel_valid_reg;
    logic [GEST_W-1:0]  rel_code_reg;
    logic               tap_upd_reg;
    logic [31:0]        tap_val_reg;
    logic               pend_valid_reg;
    logic [GEST_W-1:0]  pend_code_reg;

    logic               out_valid_reg;
    logic [GEST_W-1:0]  out_code_reg;

    logic [31:0]        held;
    logic [31:0]        gap;
    logic [31:0]        hold_now;
    logic               held_lt_tap;
    logic               gap_lt_win;
    logic [3:0]         key_idx;
    logic signed [2:0]  dr;
    logic signed [2:0]  dc;
    logic [2:0]         ar;
    logic [2:0]         ac;
    logic               rel_valid;
    logic [GEST_W-1:0]  rel_code;
    logic               tap_upd;
    logic [31:0]        tap_val;
    logic               long_press;
    logic               out_free;

    assign held        = now_reg - start_reg;
    assign gap         = now_reg - last_tap_reg;
    assign held_lt_tap = held < {16'd0, cfg.tap_limit_ms};
    assign gap_lt_win  = gap < {16'd0, cfg.double_tap_window_ms};
    assign key_idx     = lowest_index(bits_reg);

    assign dr = $signed({1'b0, last_reg[3:2]}) - $signed({1'b0, first_reg[3:2]});
    assign dc = $signed({1'b0, last_reg[1:0]}) - $signed({1'b0, first_reg[1:0]});
    assign ar = dr[2] ? 3'(-dr) : 3'(dr);
    assign ac = dc[2] ? 3'(-dc) : 3'(dc);

    always_comb begin
        rel_valid = 1'b0;
        rel_code  = GEST_TAP;
        tap_upd   = 1'b0;
        tap_val   = now_reg;
        if (fill_reg == '0) begin
            rel_valid = 1'b0;
        end else if (fill_reg == FILL_W'(1)) begin
            rel_valid = 1'b1;
            if (held_lt_tap) begin
                tap_upd = 1'b1;
                if (gap_lt_win) begin
                    rel_code = GEST_DOUBLE_TAP;
                    tap_val  = '0;
                end
            end
        end else if (CMP_W'(fill_reg) < CMP_W'(cfg.min_swipe_keys)) begin
            rel_valid = 1'b0;
        end else if (is_corner(first_reg) && is_centre(last_reg)) begin
            rel_valid = 1'b1;
            rel_code  = GEST_PINCH_IN;
        end else if (is_centre(first_reg) && is_corner(last_reg)) begin
            rel_valid = 1'b1;
            rel_code  = GEST_PINCH_OUT;
        end else if (ar > ac) begin
            rel_valid = 1'b1;
            rel_code  = dr[2] ? GEST_UP : GEST_DOWN;
        end else if (ac > ar) begin
            rel_valid = 1'b1;
            rel_code  = dc[2] ? GEST_LEFT : GEST_RIGHT;
        end
    end

    assign hold_now   = now_reg - start_reg;
    assign long_press = (bits_reg != '0) && !lp_done_reg
                        && (hold_now > {16'd0, cfg.long_press_ms})
                        && (press_reg == PRESS_W'(1));

    assign out_free        = !out_valid_reg || m_tready;
    assign stat.has_result = pend_valid_reg || long_press;
    assign stat.out_free   = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-GEST_W){1'b0}}, out_code_reg};

    // hold the item and the release decision
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            bits_reg <= s_tdata[15:0];
            now_reg  <= s_tdata[47:16];
        end
        if (cmd.measure) begin
            changed_reg   <= (bits_reg != prev_reg);
            rel_valid_reg <= rel_valid;
            rel_code_reg  <= rel_code;
            tap_upd_reg   <= tap_upd;
            tap_val_reg   <= tap_val;
        end
        if (cmd.apply) begin
            pend_code_reg <= rel_code_reg;
            if (changed_reg && bits_reg != '0) begin
                if (slot_reg == '0) begin
                    first_reg <= key_idx;
                end
                if (fill_reg != FILL_FULL || slot_reg == SLOT_LAST) begin
                    last_reg <= key_idx;
                end
            end
        end
        if (cmd.commit && stat.has_result) begin
            out_code_reg <= long_press ? GEST_LONG_PRESS : pend_code_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg       <= '0;
            start_reg      <= '0;
            last_tap_reg   <= '0;
            lp_done_reg    <= 1'b0;
            slot_reg       <= '0;
            fill_reg       <= '0;
            press_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.commit && stat.has_result) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.apply) begin
                if (changed_reg) begin
                    prev_reg <= bits_reg;
                    if (bits_reg != '0) begin
                        if (prev_reg == '0) begin
                            start_reg   <= now_reg;
                            lp_done_reg <= 1'b0;
                        end
                        slot_reg <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + SLOT_W'(1);
                        if (fill_reg != FILL_FULL) begin
                            fill_reg <= fill_reg + FILL_W'(1);
                        end
                        if (press_reg != PRESS_MAX) begin
                            press_reg <= press_reg + PRESS_W'(1);
                        end
                    end else begin
                        if (!lp_done_reg) begin
                            pend_valid_reg <= rel_valid_reg;
                            if (tap_upd_reg) begin
                                last_tap_reg <= tap_val_reg;
                            end
                        end
                        slot_reg  <= '0;
                        fill_reg  <= '0;
                        press_reg <= '0;
                    end
                end
            end
            if (cmd.commit) begin
                pend_valid_reg <= 1'b0;
                if (long_press) begin
                    lp_done_reg <= 1'b1;
                end
            end
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_FULL)
        else $error("history fill count beyond depth");

    a_empty_map_empty_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (prev_reg == '0) == (fill_reg == '0))
        else $error("ring fill disagrees with key map");

    a_press_follows_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (press_reg == '0) == (fill_reg == '0))
        else $error("press count disagrees with ring fill");

    a_commit_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && stat.has_result |-> out_free)
        else $error("result loaded over an untaken item");

endmodule

`default_nettype wire

### rtl/core/keypad_gesture_classifier.sv
`default_nettype none

// Keypad gesture classifier. Takes one scan per item (touched-key map and
// millisecond timestamp) and gives at most one gesture item per scan. Each
// scan passes in turn through capture, measure (timing compares and the
// release classification), apply (state update) and check (long press, then
// load of the output register). The check step stretches only while a new
// gesture waits for the previous one to be taken at the output. The key
// history is kept as its first and last slot plus a fill count, so release
// needs no walk over the ring. Registers: tap_limit_ms at 0x0,
// long_press_ms at 0x4, double_tap_window_ms at 0x8, min_swipe_keys at 0xC.
module keypad_gesture_classifier
    import kgc_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // touch_bits[15:0], now_ms[47:16]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_DATA_W-1:0]   m_tdata,   // gesture[3:0]
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    kgc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kgc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kgc_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .cfg      (cfg),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
